// File: rtl/sgns_pkg.sv
// Shared constants, codes and types for the sorted grid nearest search block.
package sgns_pkg;

  // Table geometry
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Fixed field widths
  localparam int VAL_W   = 48;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int ENTRY_W = 10;
  localparam int OUT_W   = 10;
  localparam int CFG_W   = 11;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_POINT_COUNT = 1'b0;

  // Item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Request from the search engine to the table memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: rtl/sorted_grid_nearest_search.sv
// Top level: APB register, search engine and grid point table memory.
//
// Usage: an input beat with in_func = load writes in_value (signed Q16.32)
// into table entry in_entry_index and produces no result. A beat with
// in_func = query searches the first point_count entries for the first one
// not less than in_value, clamps to the last entry in use and, with
// in_want_nearest set, steps down one entry when the lower neighbor is
// strictly closer. One output beat carries out_found_index.
// Throughput: loads write on accept. A query holds in_ready low while it runs;
// the search does one table read and compare per cycle, then a clamp step and
// a result staging step follow, plus 3 more steps for the nearest pick.
// in_ready returns high in the same cycle that the result is registered; a new
// query is taken only once the last one is through, so the query rate is set
// by the single read port of the table memory.
// The result sits in an output register; if the receiver stalls the next
// query finishes its search and then waits until that register frees up.
// Reset clears control state and sets point_count to 1; table contents are
// undefined until loaded. point_count lives at byte address 0.
module sorted_grid_nearest_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sgns_pkg::PADDR_W-1:0]        paddr,
  input  logic [sgns_pkg::PDATA_W-1:0]        pwdata,
  output logic [sgns_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [sgns_pkg::ENTRY_W-1:0]        in_entry_index,
  input  logic signed [sgns_pkg::VAL_W-1:0]   in_value,
  input  logic                                in_want_nearest,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sgns_pkg::OUT_W-1:0]          out_found_index
);

  logic [sgns_pkg::CFG_W-1:0]        point_count_r;
  logic                              reg_sel;
  logic                              cfg_write;
  sgns_pkg::ram_req_t                ram_req;
  logic signed [sgns_pkg::VAL_W-1:0] ram_rdata;

  // Register decode: one 32-bit word per register
  assign reg_sel   = paddr[2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= sgns_pkg::CFG_W'(1);
    end else if (cfg_write && (reg_sel == sgns_pkg::REG_POINT_COUNT)) begin
      point_count_r <= pwdata[sgns_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      sgns_pkg::REG_POINT_COUNT: prdata = sgns_pkg::PDATA_W'(point_count_r);
      default:                   prdata = '0;
    endcase
  end

  sgns_search u_search (
    .clk             (clk),
    .rst_n           (rst_n),
    .point_count     (point_count_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_value        (in_value),
    .in_want_nearest (in_want_nearest),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found_index (out_found_index),
    .ram_req         (ram_req),
    .ram_rdata       (ram_rdata)
  );

  sgns_ram #(
    .DEPTH (sgns_pkg::MAX_POINTS),
    .WIDTH (sgns_pkg::VAL_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: rtl/sgns_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sgns_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sgns_search.sv
// Search engine: table loads, binary search, clamp, nearest pick, result register.
module sgns_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [sgns_pkg::CFG_W-1:0]          point_count,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [sgns_pkg::ENTRY_W-1:0]        in_entry_index,
  input  logic signed [sgns_pkg::VAL_W-1:0]   in_value,
  input  logic                                in_want_nearest,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sgns_pkg::OUT_W-1:0]          out_found_index,
  output sgns_pkg::ram_req_t                  ram_req,
  input  logic signed [sgns_pkg::VAL_W-1:0]   ram_rdata
);

  localparam int IDX_W  = sgns_pkg::IDX_W;
  localparam int CNT_W  = sgns_pkg::CNT_W;
  localparam int VAL_W  = sgns_pkg::VAL_W;
  localparam int DIFF_W = sgns_pkg::DIFF_W;
  localparam int OUT_W  = sgns_pkg::OUT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH,
    ST_NEAR_A,
    ST_NEAR_B,
    ST_NEAR_C,
    ST_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic signed [VAL_W-1:0]   x_r, x_nxt;
  logic                      near_r, near_nxt;
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic [CNT_W-1:0]          lo_r, lo_nxt;
  logic [CNT_W-1:0]          len_r, len_nxt;
  logic [IDX_W-1:0]          mid_r, mid_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic signed [DIFF_W-1:0]  dhi_r, dhi_nxt;
  logic signed [DIFF_W-1:0]  dlo_r, dlo_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]          found_r, found_nxt;

  logic [CNT_W-1:0]  n_eff;
  logic              in_fire;
  logic              lt;
  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  lo_step;
  logic [CNT_W-1:0]  len_step;
  logic [IDX_W-1:0]  mid_first;
  logic [IDX_W-1:0]  mid_step;
  logic [IDX_W-1:0]  idx_fin;
  logic [DIFF_W-1:0] dhi_abs;
  logic [DIFF_W-1:0] dlo_abs;
  logic              closer;
  logic [31:0]       idx_ext;

  // Points in use: zero counts as one, anything above the table as the table size
  always_comb begin
    if (point_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(point_count) > 32'(sgns_pkg::MAX_POINTS)) begin
      n_eff = CNT_W'(sgns_pkg::MAX_POINTS);
    end else begin
      n_eff = CNT_W'(point_count);
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // One halving step; the compare uses the entry read at mid_r
  assign half      = len_r >> 1;
  assign lt        = ram_rdata < x_r;
  assign lo_step   = lt ? CNT_W'(mid_r) + CNT_W'(1) : lo_r;
  assign len_step  = lt ? len_r - half - CNT_W'(1) : half;
  assign mid_step  = IDX_W'(lo_step + (len_step >> 1));
  assign mid_first = IDX_W'(n_eff >> 1);

  // Clamp lower bound to last entry in use
  assign idx_fin = (lo_r >= n_r) ? IDX_W'(n_r - CNT_W'(1)) : IDX_W'(lo_r);

  // Nearest pick: lower neighbor wins only when strictly closer
  assign dhi_abs = dhi_r[DIFF_W-1] ? DIFF_W'(-dhi_r) : DIFF_W'(dhi_r);
  assign dlo_abs = dlo_r[DIFF_W-1] ? DIFF_W'(-dlo_r) : DIFF_W'(dlo_r);
  assign closer  = dlo_abs < dhi_abs;

  assign idx_ext = 32'(idx_r);

  // Memory requests: loads write on accept, reads are addressed in the cycle before their data is used
  always_comb begin
    ram_req.we    = in_fire && (in_func == sgns_pkg::FUNC_LOAD) &&
                    (32'(in_entry_index) < 32'(sgns_pkg::MAX_POINTS));
    ram_req.waddr = IDX_W'(in_entry_index);
    ram_req.wdata = in_value;
    case (state_r)
      ST_IDLE:   ram_req.raddr = mid_first;
      ST_SEARCH: ram_req.raddr = mid_step;
      ST_FINISH: ram_req.raddr = idx_fin;
      ST_NEAR_A: ram_req.raddr = idx_r - IDX_W'(1);
      default:   ram_req.raddr = mid_r;
    endcase
  end

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    near_nxt      = near_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    len_nxt       = len_r;
    mid_nxt       = mid_r;
    idx_nxt       = idx_r;
    dhi_nxt       = dhi_r;
    dlo_nxt       = dlo_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_func == sgns_pkg::FUNC_QUERY)) begin
          x_nxt     = in_value;
          near_nxt  = in_want_nearest;
          n_nxt     = n_eff;
          lo_nxt    = '0;
          len_nxt   = n_eff;
          mid_nxt   = mid_first;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        lo_nxt  = lo_step;
        len_nxt = len_step;
        mid_nxt = mid_step;
        if (len_step == '0) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        idx_nxt = idx_fin;
        if (near_r && (idx_fin != '0)) begin
          state_nxt = ST_NEAR_A;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_NEAR_A: begin
        dhi_nxt   = DIFF_W'(ram_rdata) - DIFF_W'(x_r);
        state_nxt = ST_NEAR_B;
      end
      ST_NEAR_B: begin
        dlo_nxt   = DIFF_W'(x_r) - DIFF_W'(ram_rdata);
        state_nxt = ST_NEAR_C;
      end
      ST_NEAR_C: begin
        if (closer) begin
          idx_nxt = idx_r - IDX_W'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          found_nxt     = idx_ext[OUT_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs; payload registers carry no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r     <= x_nxt;
    near_r  <= near_nxt;
    n_r     <= n_nxt;
    lo_r    <= lo_nxt;
    len_r   <= len_nxt;
    mid_r   <= mid_nxt;
    idx_r   <= idx_nxt;
    dhi_r   <= dhi_nxt;
    dlo_r   <= dlo_nxt;
    found_r <= found_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found_index = found_r;

  // Search window never runs past the entries in use
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> ((32'(lo_r) + 32'(len_r)) <= 32'(n_r)))
    else $error("search window beyond points in use");

  // Every search read addresses an entry in use
  a_mid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (CNT_W'(mid_r) < n_r))
    else $error("search read outside points in use");

  // Clamped index stays below the point count
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NEAR_A || state_r == ST_DONE) |-> (CNT_W'(idx_r) < n_r))
    else $error("result index not clamped");

  // Table writes only happen while no query is in flight
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (state_r == ST_IDLE))
    else $error("table write during a query");

  // An accepted query always starts the search
  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func == sgns_pkg::FUNC_QUERY) |=> (state_r == ST_SEARCH))
    else $error("query accepted without starting search");

endmodule
